// ===== rtl/bba_pkg.sv =====
// shared constants for the bitmap block allocator: field widths, status and mode codes
// register addresses and default sizing; no dependencies
`timescale 1ns / 1ps

package bba_pkg;

	// default sizing
	localparam int DEF_MAX_BLOCKS    = 4096;
	localparam int DEF_MAP_WORD_BITS = 64;

	// fixed field widths
	localparam int BLK_NUM_W = 12;
	localparam int TOTAL_W   = 13;
	localparam int STATUS_W  = 2;
	localparam int APB_AW    = 2;
	localparam int APB_DW    = 32;

	// request mode
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// result status
	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL        = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DOUBLE_FREE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE       = 2'd3;

	// register byte addresses
	localparam logic [APB_AW-1:0] REG_TOTAL_BLOCKS = 2'd0;

endpackage

// ===== rtl/bba_ffz.sv =====
// find-first-free unit: lowest clear bit of a map word among the eligible bits
// takes its default word width from bba_pkg; pure combinational
`timescale 1ns / 1ps

module bba_ffz
	import bba_pkg::*;
#(
	parameter int WORD_BITS = DEF_MAP_WORD_BITS
) (
	input  logic [WORD_BITS-1:0]         word,
	input  logic [WORD_BITS-1:0]         elig,
	output logic                         found,
	output logic [WORD_BITS-1:0]         pick,
	output logic [$clog2(WORD_BITS)-1:0] idx
);

	localparam int BI_W = $clog2(WORD_BITS);

	logic [WORD_BITS-1:0] free_bits;

	// isolate the lowest free bit, then encode it
	assign free_bits = ~word & elig;
	assign pick      = free_bits & (~free_bits + 1'b1);
	assign found     = |free_bits;

	always_comb begin
		idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (pick[i]) begin
				idx = idx | BI_W'(i);
			end
		end
	end

endmodule

// ===== rtl/bitmap_block_allocator.sv =====
// allocate streams the map words below the limit through bba_ffz until a free bit shows up, out of
//   blocks when none does; free steps to the word holding the block, then tests and clears its bit,
//   an out-of-range free goes straight to the result; a stalled output holds the result back
// throughput: one item at a time, in_stall drops as out_valid rises so the next item can be taken
// reset: map cleared by a sweep over all MAP_WORDS words, in_stall high meanwhile; total_blocks
//   resets to 4096, configuration writes are taken during the sweep; needs bba_pkg, bba_ffz
`timescale 1ns / 1ps

module bitmap_block_allocator
	import bba_pkg::*;
#(
	parameter int MAX_BLOCKS    = DEF_MAX_BLOCKS,
	parameter int MAP_WORD_BITS = DEF_MAP_WORD_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,

	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [APB_AW-1:0]    paddr,
	input  logic [APB_DW-1:0]    pwdata,
	output logic [APB_DW-1:0]    prdata,
	output logic                 pready,

	// request channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 mode,
	input  logic [BLK_NUM_W-1:0] block_number,

	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [BLK_NUM_W-1:0] allocated_block,
	output logic [STATUS_W-1:0]  status
);

	// map geometry
	localparam int MAP_WORDS = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BI_W      = $clog2(MAP_WORD_BITS);
	// running bit base, wide enough for one step past the last word
	localparam int SUM_W     = $clog2(MAP_WORDS * MAP_WORD_BITS + MAP_WORD_BITS + 1);
	localparam logic [MAP_WORD_BITS-1:0] W_ONES = '1;

	// sequencer states
	localparam logic [2:0] S_CLR  = 3'd0;  // clearing sweep after reset
	localparam logic [2:0] S_IDLE = 3'd1;  // waiting for an item
	localparam logic [2:0] S_SCAN = 3'd2;  // allocate: stream words through the ffz unit
	localparam logic [2:0] S_SEEK = 3'd3;  // free: step to the word holding the block
	localparam logic [2:0] S_FCHK = 3'd4;  // free: test and clear the bit
	localparam logic [2:0] S_DONE = 3'd5;  // hand result to the output register

	logic [2:0]               state_q;
	logic [TOTAL_W-1:0]       total_blocks_q;
	logic [BLK_NUM_W-1:0]     blk_q;
	logic [WA_W-1:0]          w_q;        // word address counter
	logic [SUM_W-1:0]         base_q;     // first block number of word w_q
	logic                     rd_vld_s1;  // scan read in flight
	logic [WA_W-1:0]          rd_word_s1;
	logic [SUM_W-1:0]         rd_base_s1;
	logic [MAP_WORD_BITS-1:0] rdata_s1;
	logic [BLK_NUM_W-1:0]     res_blk_q;
	logic [STATUS_W-1:0]      res_st_q;
	logic                     out_valid_q;
	logic [BLK_NUM_W-1:0]     out_blk_q;
	logic [STATUS_W-1:0]      out_st_q;

	// usage map, one bit per block, no reset: the clearing sweep zeroes it
	logic [MAP_WORD_BITS-1:0] mem [MAP_WORDS];
	logic                     mem_we;
	logic [WA_W-1:0]          mem_waddr;
	logic [MAP_WORD_BITS-1:0] mem_wdata;

	logic [SUM_W-1:0]         lim;        // effective block count
	logic [SUM_W-1:0]         rem;        // blocks left below the limit in the scanned word
	logic [MAP_WORD_BITS-1:0] elig;
	logic                     ffz_found;
	logic [MAP_WORD_BITS-1:0] ffz_pick;
	logic [BI_W-1:0]          ffz_idx;
	logic [BI_W-1:0]          free_bit;
	logic [MAP_WORD_BITS-1:0] free_onehot;
	logic                     rd_issue;
	logic                     seek_hit;
	logic                     accept_in;
	logic                     out_free;
	logic                     cfg_wr;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == REG_TOTAL_BLOCKS);
	assign prdata = (paddr == REG_TOTAL_BLOCKS) ? APB_DW'(total_blocks_q) : '0;

	// counts above capacity clamp to capacity
	assign lim = (32'(total_blocks_q) > 32'(MAX_BLOCKS)) ? SUM_W'(MAX_BLOCKS)
	                                                       : SUM_W'(total_blocks_q);

	// handshakes
	assign in_stall  = (state_q != S_IDLE);
	assign accept_in = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid       = out_valid_q;
	assign allocated_block = out_blk_q;
	assign status          = out_st_q;

	// eligible bits of the scanned word: those whose block lies below the limit
	assign rem  = lim - rd_base_s1;
	assign elig = (32'(rem) >= 32'(MAP_WORD_BITS)) ? W_ONES : ~(W_ONES << rem[BI_W-1:0]);

	bba_ffz #(
		.WORD_BITS(MAP_WORD_BITS)
	) u_ffz (
		.word  (rdata_s1),
		.elig  (elig),
		.found (ffz_found),
		.pick  (ffz_pick),
		.idx   (ffz_idx)
	);

	// scan keeps one read in flight; it stops issuing once a free bit shows up
	assign rd_issue = (state_q == S_SCAN) && (base_q < lim) && !(rd_vld_s1 && ffz_found);

	// free: word found when the block lies below the next word's base
	assign seek_hit    = 32'(blk_q) < (32'(base_q) + 32'(MAP_WORD_BITS));
	assign free_bit    = BI_W'(32'(blk_q) - 32'(rd_base_s1));
	assign free_onehot = MAP_WORD_BITS'(1) << free_bit;

	// map write port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rd_word_s1;
		mem_wdata = rdata_s1;
		unique case (state_q)
			S_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = w_q;
				mem_wdata = '0;
			end
			S_SCAN: begin
				mem_we    = rd_vld_s1 && ffz_found;
				mem_wdata = rdata_s1 | ffz_pick;
			end
			S_FCHK: begin
				mem_we    = |(rdata_s1 & free_onehot);
				mem_wdata = rdata_s1 & ~free_onehot;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// map memory, read data registered; the read address is the word counter
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= mem[w_q];
	end

	// request payload, held for the whole item
	always_ff @(posedge clk) begin
		if (accept_in) begin
			blk_q <= block_number;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLR;
			total_blocks_q <= TOTAL_W'(4096);
			w_q            <= '0;
			base_q         <= '0;
			rd_vld_s1      <= 1'b0;
			rd_word_s1     <= '0;
			rd_base_s1     <= '0;
			res_blk_q      <= '0;
			res_st_q       <= ST_OK;
			out_valid_q    <= 1'b0;
			out_blk_q      <= '0;
			out_st_q       <= ST_OK;
		end else begin
			if (cfg_wr) begin
				total_blocks_q <= pwdata[TOTAL_W-1:0];
			end

			// a result taken while a new one is loaded stays valid, see S_DONE
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end

			rd_vld_s1 <= rd_issue;
			if (rd_issue) begin
				rd_word_s1 <= w_q;
				rd_base_s1 <= base_q;
				w_q        <= w_q + 1'b1;
				base_q     <= base_q + SUM_W'(MAP_WORD_BITS);
			end

			unique case (state_q)
				S_CLR: begin
					// one word zeroed per cycle
					if (w_q == WA_W'(MAP_WORDS - 1)) begin
						w_q     <= '0;
						state_q <= S_IDLE;
					end else begin
						w_q <= w_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept_in) begin
						w_q    <= '0;
						base_q <= '0;
						res_blk_q <= '0;
						if (mode == MODE_FREE) begin
							if (32'(block_number) >= 32'(lim)) begin
								res_st_q <= ST_RANGE;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_SEEK;
							end
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (rd_vld_s1 && ffz_found) begin
						res_blk_q <= BLK_NUM_W'(32'(rd_base_s1) + 32'(ffz_idx));
						res_st_q  <= ST_OK;
						state_q   <= S_DONE;
					end else if (!rd_issue && !rd_vld_s1) begin
						// every word below the limit is full
						res_st_q <= ST_FULL;
						state_q  <= S_DONE;
					end
				end
				S_SEEK: begin
					if (seek_hit) begin
						// word w_q is read this cycle, data next cycle
						rd_word_s1 <= w_q;
						rd_base_s1 <= base_q;
						state_q    <= S_FCHK;
					end else begin
						w_q    <= w_q + 1'b1;
						base_q <= base_q + SUM_W'(MAP_WORD_BITS);
					end
				end
				S_FCHK: begin
					res_st_q <= (|(rdata_s1 & free_onehot)) ? ST_OK : ST_DOUBLE_FREE;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_blk_q   <= res_blk_q;
						out_st_q    <= res_st_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// an accepted item always leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept_in |=> (state_q != S_IDLE))
		else $error("accepted item did not start");

	// a failed request never reports a block number
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_st_q != ST_OK)) |-> (out_blk_q == '0))
		else $error("failed request carries a block number");

	// the scan never reads beyond the block limit
	a_scan_limit: assert property (@(posedge clk) disable iff (!arst_n)
		rd_issue |-> (base_q < lim))
		else $error("scan read past the block limit");

	// a finished result waits while the output register is stalled
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && out_stall) |=> (state_q == S_DONE))
		else $error("result dropped while output stalled");

endmodule

// ===== sim/tb_bitmap_block_allocator.sv =====
// self-checking testbench for bitmap_block_allocator: directed table, then random
// allocate/free traffic over many block counts with random idling on both channels
// depends on bba_pkg and the allocator rtl
`timescale 1ns / 1ps

module tb_bitmap_block_allocator;
	import bba_pkg::*;

	// one grant as the block reports it
	typedef struct packed {
		logic [BLK_NUM_W-1:0] blk;
		logic [STATUS_W-1:0]  status;
	} grant_t;

	// one row of the directed table
	typedef struct packed {
		bit                   set_count;  // program total_blocks before the item
		logic [TOTAL_W-1:0]   count;
		logic                 op;
		logic [BLK_NUM_W-1:0] blk;
		bit                   typed;      // grant given below instead of predicted
		grant_t               want;
	} directed_row_t;

	localparam int unsigned CAPACITY        = DEF_MAX_BLOCKS;
	localparam int unsigned ITEMS_PER_PHASE = 136;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [APB_AW-1:0]    paddr;
	logic [APB_DW-1:0]    pwdata;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;
	logic                 in_valid;
	logic                 in_stall;
	logic                 mode;
	logic [BLK_NUM_W-1:0] block_number;
	logic                 out_valid;
	logic                 out_stall;
	logic [BLK_NUM_W-1:0] allocated_block;
	logic [STATUS_W-1:0]  status;

	// predictor copy of the usage map and of the block count register
	bit [CAPACITY-1:0] used_map;
	int unsigned       block_count_cfg;

	grant_t      awaited_grants[$];
	int          mismatches;
	int unsigned request_gap_pct;
	int unsigned result_stall_pct;

	// directed table, map empty and count 4096 at its start
	directed_row_t plan [23] = '{
		// freeing a free block straight after reset
		'{1'b0, 13'd0,    MODE_FREE,  12'd0,    1'b1, '{12'd0, ST_DOUBLE_FREE}},
		'{1'b0, 13'd0,    MODE_ALLOC, 12'd0,    1'b1, '{12'd0, ST_OK}},
		// block_number all ones is ignored on allocate
		'{1'b0, 13'd0,    MODE_ALLOC, 12'hfff,  1'b1, '{12'd1, ST_OK}},
		'{1'b0, 13'd0,    MODE_ALLOC, 12'd0,    1'b1, '{12'd2, ST_OK}},
		'{1'b0, 13'd0,    MODE_FREE,  12'd1,    1'b1, '{12'd0, ST_OK}},
		// the hole just made is the lowest free block
		'{1'b0, 13'd0,    MODE_ALLOC, 12'd0,    1'b1, '{12'd1, ST_OK}},
		'{1'b0, 13'd0,    MODE_FREE,  12'hfff,  1'b1, '{12'd0, ST_DOUBLE_FREE}},
		// three blocks, all taken: out of blocks
		'{1'b1, 13'd3,    MODE_ALLOC, 12'd0,    1'b1, '{12'd0, ST_FULL}},
		'{1'b0, 13'd0,    MODE_FREE,  12'd3,    1'b1, '{12'd0, ST_RANGE}},
		'{1'b0, 13'd0,    MODE_FREE,  12'hfff,  1'b1, '{12'd0, ST_RANGE}},
		'{1'b0, 13'd0,    MODE_FREE,  12'd2,    1'b1, '{12'd0, ST_OK}},
		'{1'b0, 13'd0,    MODE_ALLOC, 12'd0,    1'b1, '{12'd2, ST_OK}},
		// zero blocks managed
		'{1'b1, 13'd0,    MODE_ALLOC, 12'd0,    1'b1, '{12'd0, ST_FULL}},
		'{1'b0, 13'd0,    MODE_FREE,  12'd0,    1'b1, '{12'd0, ST_RANGE}},
		// register maximum is clamped to capacity
		'{1'b1, 13'd8191, MODE_ALLOC, 12'd0,    1'b1, '{12'd3, ST_OK}},
		'{1'b0, 13'd0,    MODE_FREE,  12'hfff,  1'b1, '{12'd0, ST_DOUBLE_FREE}},
		'{1'b1, 13'd4096, MODE_FREE,  12'd2048, 1'b1, '{12'd0, ST_DOUBLE_FREE}},
		'{1'b1, 13'd4095, MODE_FREE,  12'hfff,  1'b1, '{12'd0, ST_RANGE}},
		'{1'b1, 13'd4097, MODE_FREE,  12'hfff,  1'b1, '{12'd0, ST_DOUBLE_FREE}},
		// word boundary traffic, predicted
		'{1'b1, 13'd70,   MODE_ALLOC, 12'd0,    1'b0, '{12'd0, ST_OK}},
		'{1'b0, 13'd0,    MODE_FREE,  12'd63,   1'b0, '{12'd0, ST_OK}},
		'{1'b0, 13'd0,    MODE_FREE,  12'd3,    1'b0, '{12'd0, ST_OK}},
		'{1'b0, 13'd0,    MODE_ALLOC, 12'd0,    1'b0, '{12'd0, ST_OK}}
	};

	// block counts of the random phases: tiny, word edges, zero, clamp, full size
	int unsigned phase_counts [14] = '{
		4096, 1, 64, 65, 0, 130, 8191, 200, 63, 4096, 2, 1000, 127, 4097
	};

	bitmap_block_allocator u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.mode            (mode),
		.block_number    (block_number),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.allocated_block (allocated_block),
		.status          (status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#100_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// blocks the allocator may hand out, register value clamped to capacity
	function automatic int unsigned block_limit();
		return (block_count_cfg > CAPACITY) ? CAPACITY : block_count_cfg;
	endfunction

	// first-fit allocate or checked free, updating the predictor map
	function automatic grant_t first_fit_grant(input logic op, input logic [BLK_NUM_W-1:0] blk);
		grant_t      g;
		int unsigned lim;
		g.blk    = '0;
		g.status = ST_OK;
		lim      = block_limit();
		if (op == MODE_ALLOC) begin
			g.status = ST_FULL;
			for (int unsigned i = 0; i < lim; i++) begin
				if (!used_map[i]) begin
					used_map[i] = 1'b1;
					g.blk       = BLK_NUM_W'(i);
					g.status    = ST_OK;
					break;
				end
			end
		end else if (32'(blk) >= lim) begin
			g.status = ST_RANGE;
		end else if (!used_map[blk]) begin
			g.status = ST_DOUBLE_FREE;
		end else begin
			used_map[blk] = 1'b0;
		end
		return g;
	endfunction

	// a used block below the limit from a random start, or start; lim must be nonzero
	function automatic logic [BLK_NUM_W-1:0] pick_used_block(input int unsigned lim);
		int unsigned start;
		int unsigned idx;
		start = $urandom_range(0, lim - 1);
		for (int unsigned k = 0; k < lim; k++) begin
			idx = (start + k) % lim;
			if (used_map[idx])
				return BLK_NUM_W'(idx);
		end
		return BLK_NUM_W'(start);
	endfunction

	// hand one item to the block, then record the grant it must produce
	task automatic issue_request(input logic op, input logic [BLK_NUM_W-1:0] blk,
		input bit typed, input grant_t typed_grant);
		grant_t predicted;
		while ($urandom_range(0, 99) < request_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= op;
		block_number <= blk;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// accepted at this edge; the map follows in request order
		predicted = first_fit_grant(op, blk);
		awaited_grants.push_back(typed ? typed_grant : predicted);
	endtask

	// hold off requests until every grant is back, then let the block settle
	task automatic drain_grants();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (awaited_grants.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// program total_blocks with the block idle: setup cycle, then access cycle
	task automatic write_block_count(input int unsigned value);
		drain_grants();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_TOTAL_BLOCKS;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		block_count_cfg = value & 32'h1fff;
	endtask

	// result side back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < result_stall_pct);
	end

	// compare every accepted grant with the oldest one awaited
	always @(posedge clk) begin
		grant_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_grants.size() == 0) begin
				$error("grant with no request pending: allocated_block %0d status %0d",
					allocated_block, status);
				mismatches++;
			end else begin
				want = awaited_grants.pop_front();
				if (allocated_block !== want.blk) begin
					$error("allocated_block: expected %0d, got %0d", want.blk, allocated_block);
					mismatches++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int unsigned lim;
		int unsigned draw;
		int unsigned stage;
		logic [BLK_NUM_W-1:0] blk;

		// everything known from time zero, reset asserted at the start
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		in_valid         = 1'b0;
		mode             = MODE_ALLOC;
		block_number     = '0;
		out_stall        = 1'b0;
		used_map         = '0;
		block_count_cfg  = CAPACITY;
		mismatches       = 0;
		request_gap_pct  = 30;
		result_stall_pct = 65;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed table; the clearing sweep after reset shows up as in_stall
		foreach (plan[r]) begin
			if (plan[r].set_count)
				write_block_count(32'(plan[r].count));
			issue_request(plan[r].op, plan[r].blk, plan[r].typed, plan[r].want);
		end

		// random phases, one block count each, map carried across phases
		foreach (phase_counts[p]) begin
			// receiver stalls then sender gaps dominate, last third runs flat out
			stage = (p * 3) / $size(phase_counts);
			case (stage)
				0: begin
					request_gap_pct  = 30;
					result_stall_pct = 65;
				end
				1: begin
					request_gap_pct  = 65;
					result_stall_pct = 30;
				end
				default: begin
					request_gap_pct  = 0;
					result_stall_pct = 0;
				end
			endcase
			write_block_count(phase_counts[p]);
			repeat (ITEMS_PER_PHASE) begin
				// now and then let the block run completely dry
				if ($urandom_range(0, 149) == 0)
					drain_grants();
				lim  = block_limit();
				draw = $urandom_range(0, 99);
				if (draw < 50) begin
					// allocate, with a junk block number riding along
					blk = BLK_NUM_W'($urandom_range(0, CAPACITY - 1));
					issue_request(MODE_ALLOC, blk, 1'b0, '0);
				end else if (draw < 85 && lim != 0) begin
					// well-formed free, of a block in use where there is one
					issue_request(MODE_FREE, pick_used_block(lim), 1'b0, '0);
				end else begin
					// noise: any number, or right at the edge of the range
					case ($urandom_range(0, 2))
						0:       blk = BLK_NUM_W'($urandom_range(0, CAPACITY - 1));
						1:       blk = BLK_NUM_W'(lim);
						default: blk = BLK_NUM_W'(lim - 1);
					endcase
					issue_request(MODE_FREE, blk, 1'b0, '0);
				end
			end
		end

		// all requests in, wait for the last grants and a scan's worth of quiet
		in_valid <= 1'b0;
		while (awaited_grants.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
